/* rtl/core/htpd_pkg.sv */
// Shared types and codes for the heading turn PID drive.
// Holds register map indexes, item kinds, phase codes and the result record.
// No dependencies.
package htpd_pkg;

  // Register map, one 32-bit word per register
  localparam logic [2:0] RegTurnAngle  = 3'd0;
  localparam logic [2:0] RegGainProp   = 3'd1;
  localparam logic [2:0] RegGainInteg  = 3'd2;
  localparam logic [2:0] RegGainDeriv  = 3'd3;
  localparam logic [2:0] RegBandWidth  = 3'd4;
  localparam logic [2:0] RegSettle     = 3'd5;
  localparam logic [2:0] RegDriveMin   = 3'd6;
  localparam logic [2:0] RegDriveMax   = 3'd7;

  // Turn phase, also reported with each result
  localparam logic [1:0] PhaseIdle = 2'd0;
  localparam logic [1:0] PhaseAvg  = 2'd1;
  localparam logic [1:0] PhaseRun  = 2'd2;

  // What a request turned into, carried down the pipeline
  localparam logic [1:0] KindIdle = 2'd0;
  localparam logic [1:0] KindAvg  = 2'd1;
  localparam logic [1:0] KindRun  = 2'd2;
  localparam logic [1:0] KindDone = 2'd3;

  localparam logic [16:0] ConfirmCount = 17'd3;
  localparam logic [16:0] BandCntMax   = 17'h1ffff;

  // Output queue, power of two
  localparam int OutDepth = 8;
  localparam int OutPtrW  = $clog2(OutDepth);

  localparam int AccW = 48;
  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  typedef struct packed {
    logic        drive_valid;
    logic [10:0] right_compare;
    logic        right_reverse;
    logic [10:0] left_compare;
    logic        left_reverse;
    logic        turn_done;
    logic [1:0]  phase_now;
  } result_t;

endpackage

/* rtl/core/heading_turn_pid_drive.sv */
// Heading turn controller: yaw averaging, wrapped error, positional PID, PWM mapping.
// Depends on htpd_pkg for codes and the result record.
// One request per cycle while sample_stall is low; result_valid rises once a result is in the queue.
// Stages: input reg, control/state, multiply, accumulate, clamp/PWM into an 8-entry queue;
// sample_stall rises once queued plus in-flight requests reach 8.
// Reset (rst, synchronous): registers to defaults, phase idle, PID and band state cleared.
module heading_turn_pid_drive #(
  parameter int unsigned PWM_PERIOD      = 2000,
  parameter int unsigned AVERAGE_SAMPLES = 10
) (
  input  logic               clk,
  input  logic               rst,
  // APB-style configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // sample channel
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic               start_req,
  input  logic signed [15:0] yaw,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic               drive_valid,
  output logic [10:0]        right_compare,
  output logic               right_reverse,
  output logic [10:0]        left_compare,
  output logic               left_reverse,
  output logic               turn_done,
  output logic [1:0]         phase_now
);

  localparam int CntW     = $clog2(AVERAGE_SAMPLES + 1);
  localparam int SumW     = 16 + CntW;
  localparam int DivShift = SumW + CntW;
  localparam int DivW     = DivShift + 1;
  localparam logic [DivW-1:0] DivMul =
    DivW'(((64'd1 << DivShift) + 64'(AVERAGE_SAMPLES) - 64'd1) / 64'(AVERAGE_SAMPLES));
  localparam logic [CntW-1:0] AvgCount = CntW'(AVERAGE_SAMPLES);
  localparam logic [15:0]     Period   = 16'(PWM_PERIOD);

  // configuration registers
  logic signed [15:0] turn_angle;
  logic [19:0]        gain_prop;
  logic [19:0]        gain_integ;
  logic [19:0]        gain_deriv;
  logic [14:0]        band_width;
  logic [16:0]        settle_limit;
  logic [10:0]        drive_min;
  logic [10:0]        drive_max;

  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_angle   <= -16'sd16384;
      gain_prop    <= 20'd34560;
      gain_integ   <= 20'd605;
      gain_deriv   <= 20'd17280;
      band_width   <= 15'd364;
      settle_limit <= 17'd100000;
      drive_min    <= 11'd150;
      drive_max    <= 11'd1100;
    end else if (cfg_write) begin
      case (paddr[4:2])
        htpd_pkg::RegTurnAngle: turn_angle   <= pwdata[15:0];
        htpd_pkg::RegGainProp:  gain_prop    <= pwdata[19:0];
        htpd_pkg::RegGainInteg: gain_integ   <= pwdata[19:0];
        htpd_pkg::RegGainDeriv: gain_deriv   <= pwdata[19:0];
        htpd_pkg::RegBandWidth: band_width   <= pwdata[14:0];
        htpd_pkg::RegSettle:    settle_limit <= pwdata[16:0];
        htpd_pkg::RegDriveMin:  drive_min    <= pwdata[10:0];
        htpd_pkg::RegDriveMax:  drive_max    <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      htpd_pkg::RegTurnAngle: prdata = {16'd0, turn_angle};
      htpd_pkg::RegGainProp:  prdata = {12'd0, gain_prop};
      htpd_pkg::RegGainInteg: prdata = {12'd0, gain_integ};
      htpd_pkg::RegGainDeriv: prdata = {12'd0, gain_deriv};
      htpd_pkg::RegBandWidth: prdata = {17'd0, band_width};
      htpd_pkg::RegSettle:    prdata = {15'd0, settle_limit};
      htpd_pkg::RegDriveMin:  prdata = {21'd0, drive_min};
      htpd_pkg::RegDriveMax:  prdata = {21'd0, drive_max};
      default:                prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic               v0;
  logic               s0_start;
  logic signed [15:0] s0_yaw;
  logic               sample_take;

  assign sample_take = sample_valid & ~sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= sample_take;
    end
    if (sample_take) begin
      s0_start <= start_req;
      s0_yaw   <= yaw;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: phase, averaging, error and band tracking
  // ---------------------------------------------------------------------------
  logic [1:0]             phase;
  logic [CntW-1:0]        sample_count;
  logic signed [SumW-1:0] yaw_sum;
  logic signed [15:0]     target_heading;
  logic signed [15:0]     last_error;
  logic                   confirmed;
  logic [16:0]            band_counter;

  logic [1:0]             phase_next;
  logic [CntW-1:0]        sample_count_next;
  logic signed [SumW-1:0] yaw_sum_next;
  logic signed [15:0]     target_heading_next;
  logic signed [15:0]     last_error_next;
  logic                   confirmed_next;
  logic [16:0]            band_counter_next;

  logic [1:0]             phase_eff;
  logic [1:0]             a_kind;
  logic signed [15:0]     err;
  logic [15:0]            err_mag;
  logic                   in_band;
  logic signed [16:0]     err_diff;
  logic signed [SumW-1:0] sum_base;
  logic signed [SumW-1:0] sum_new;
  logic [CntW-1:0]        count_base;
  logic [CntW-1:0]        count_new;
  logic [SumW-1:0]        sum_mag;
  logic [SumW+DivW-1:0]   div_prod;
  logic [15:0]            quot;
  logic signed [15:0]     avg;
  logic [16:0]            cnt;
  logic                   conf;
  logic                   finish;

  function automatic logic [16:0] sat_inc(input logic [16:0] c);
    return (c == htpd_pkg::BandCntMax) ? c : c + 17'd1;
  endfunction

  assign err      = target_heading - s0_yaw;
  assign err_mag  = err[15] ? 16'(-err) : 16'(err);
  assign in_band  = err_mag < {1'b0, band_width};
  assign err_diff = 17'(err) - 17'(last_error);

  // running sum and divide by reciprocal multiply (exact over the sum's range)
  assign sum_base   = s0_start ? '0 : yaw_sum;
  assign count_base = s0_start ? '0 : sample_count;
  assign sum_new    = sum_base + SumW'(s0_yaw);
  assign count_new  = count_base + CntW'(1);
  assign sum_mag    = sum_new[SumW-1] ? SumW'(-sum_new) : SumW'(sum_new);
  assign div_prod   = (SumW+DivW)'(sum_mag) * (SumW+DivW)'(DivMul);
  assign quot       = div_prod[DivShift +: 16];
  assign avg        = sum_new[SumW-1] ? 16'(-quot) : quot;

  always_comb begin
    phase_eff           = s0_start ? htpd_pkg::PhaseAvg : phase;
    phase_next          = phase;
    sample_count_next   = sample_count;
    yaw_sum_next        = yaw_sum;
    target_heading_next = target_heading;
    last_error_next     = s0_start ? 16'sd0 : last_error;
    confirmed_next      = s0_start ? 1'b0 : confirmed;
    band_counter_next   = s0_start ? 17'd0 : band_counter;
    a_kind              = htpd_pkg::KindIdle;
    cnt                 = band_counter;
    conf                = confirmed;
    finish              = 1'b0;

    case (phase_eff)
      htpd_pkg::PhaseAvg: begin
        a_kind            = htpd_pkg::KindAvg;
        yaw_sum_next      = sum_new;
        sample_count_next = count_new;
        if (count_new >= AvgCount) begin
          target_heading_next = avg + turn_angle;
          phase_next          = htpd_pkg::PhaseRun;
        end else begin
          phase_next = htpd_pkg::PhaseAvg;
        end
      end
      htpd_pkg::PhaseRun: begin
        // confirm: in-band samples counted until the third; misses don't clear
        if (in_band && !conf) begin
          cnt = sat_inc(cnt);
          if (cnt >= htpd_pkg::ConfirmCount) begin
            conf = 1'b1;
            cnt  = 17'd0;
          end
        end
        if (conf) begin
          if (cnt > settle_limit) begin
            finish = 1'b1;
            conf   = 1'b0;
            cnt    = 17'd0;
          end else if (in_band) begin
            cnt = sat_inc(cnt);
          end else begin
            conf = 1'b0;
            cnt  = 17'd0;
          end
        end
        confirmed_next    = conf;
        band_counter_next = cnt;
        if (finish) begin
          a_kind     = htpd_pkg::KindDone;
          phase_next = htpd_pkg::PhaseIdle;
        end else begin
          a_kind          = htpd_pkg::KindRun;
          last_error_next = err;
        end
      end
      default: begin
        phase_next = htpd_pkg::PhaseIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= htpd_pkg::PhaseIdle;
      sample_count   <= '0;
      yaw_sum        <= '0;
      target_heading <= '0;
      last_error     <= '0;
      confirmed      <= 1'b0;
      band_counter   <= '0;
    end else if (v0) begin
      phase          <= phase_next;
      sample_count   <= sample_count_next;
      yaw_sum        <= yaw_sum_next;
      target_heading <= target_heading_next;
      last_error     <= last_error_next;
      confirmed      <= confirmed_next;
      band_counter   <= band_counter_next;
    end
  end

  logic               v1;
  logic [1:0]         kind1;
  logic               clear1;
  logic signed [15:0] err1;
  logic signed [16:0] diff1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    kind1  <= a_kind;
    clear1 <= s0_start;
    err1   <= err;
    diff1  <= err_diff;
  end

  // ---------------------------------------------------------------------------
  // Stage B: gain products
  // ---------------------------------------------------------------------------
  logic               v2;
  logic [1:0]         kind2;
  logic               clear2;
  logic signed [36:0] prop2;
  logic signed [36:0] integ2;
  logic signed [37:0] deriv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    kind2  <= kind1;
    clear2 <= clear1;
    prop2  <= $signed({1'b0, gain_prop}) * err1;
    integ2 <= $signed({1'b0, gain_integ}) * err1;
    deriv2 <= $signed({1'b0, gain_deriv}) * diff1;
  end

  // ---------------------------------------------------------------------------
  // Stage C: PID sum with integral before update, saturating integral
  // ---------------------------------------------------------------------------
  logic signed [htpd_pkg::AccW-1:0] integral_acc;
  logic signed [htpd_pkg::AccW-1:0] integral_acc_next;
  logic signed [htpd_pkg::AccW:0]   acc_sum;
  logic signed [49:0]               pid_sum;
  logic [49:0]                      pid_mag;

  assign pid_sum = 50'(integral_acc) + 50'(prop2) + 50'(deriv2);
  assign pid_mag = pid_sum[49] ? 50'(-pid_sum) : 50'(pid_sum);
  assign acc_sum = (htpd_pkg::AccW+1)'(integral_acc) + (htpd_pkg::AccW+1)'(integ2);

  always_comb begin
    if (acc_sum[htpd_pkg::AccW] != acc_sum[htpd_pkg::AccW-1]) begin
      integral_acc_next = acc_sum[htpd_pkg::AccW] ? htpd_pkg::AccMin : htpd_pkg::AccMax;
    end else begin
      integral_acc_next = acc_sum[htpd_pkg::AccW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
    end else if (v2) begin
      if (clear2) begin
        integral_acc <= '0;
      end else if (kind2 == htpd_pkg::KindRun) begin
        integral_acc <= integral_acc_next;
      end
    end
  end

  logic        v3;
  logic [1:0]  kind3;
  logic        neg3;
  logic [29:0] mag3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    kind3 <= kind2;
    neg3  <= pid_sum[49];
    mag3  <= pid_mag[49:20];
  end

  // ---------------------------------------------------------------------------
  // Stage D: clamp and map to compare values
  // ---------------------------------------------------------------------------
  function automatic logic [11:0] pwm_map(input logic neg, input logic [10:0] mag);
    logic [15:0] c;
    logic        rev;
    if (neg && mag != 11'd0) begin
      rev = 1'b1;
      if ({5'd0, mag} >= Period) begin
        c = 16'd1;
      end else begin
        c = Period - {5'd0, mag};
      end
    end else begin
      rev = 1'b0;
      c   = (mag == 11'd0) ? 16'd1 : {5'd0, mag};
    end
    if (c > Period) begin
      c = Period;
    end
    return {rev, c[10:0]};
  endfunction

  logic [10:0]      drive_mag;
  logic [10:0]      drive_clamped;
  logic [11:0]      right_map;
  logic [11:0]      left_map;
  htpd_pkg::result_t d_result;

  assign drive_mag     = (mag3 > {19'd0, drive_max}) ? drive_max : mag3[10:0];
  assign drive_clamped = (drive_mag < drive_min) ? drive_min : drive_mag;
  assign right_map     = pwm_map(neg3, drive_clamped);
  assign left_map      = pwm_map(~neg3, drive_clamped);

  always_comb begin
    d_result = '0;
    case (kind3)
      htpd_pkg::KindAvg: begin
        d_result.phase_now = htpd_pkg::PhaseAvg;
      end
      htpd_pkg::KindRun: begin
        d_result.drive_valid   = 1'b1;
        d_result.right_compare = right_map[10:0];
        d_result.right_reverse = right_map[11];
        d_result.left_compare  = left_map[10:0];
        d_result.left_reverse  = left_map[11];
        d_result.phase_now     = htpd_pkg::PhaseRun;
      end
      htpd_pkg::KindDone: begin
        // stop values
        d_result.drive_valid   = 1'b1;
        d_result.right_compare = 11'd1;
        d_result.left_compare  = 11'd1;
        d_result.turn_done     = 1'b1;
        d_result.phase_now     = htpd_pkg::PhaseRun;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result queue; stall requests when queue plus pipeline could overflow it
  // ---------------------------------------------------------------------------
  htpd_pkg::result_t             out_queue [htpd_pkg::OutDepth];
  logic [htpd_pkg::OutPtrW-1:0]  wr_ptr;
  logic [htpd_pkg::OutPtrW-1:0]  rd_ptr;
  logic [htpd_pkg::OutPtrW:0]    out_count;
  logic [2:0]                    inflight;
  logic [htpd_pkg::OutPtrW+1:0]  occupancy;
  logic                          pop;
  htpd_pkg::result_t             head;

  assign inflight  = 3'(v0) + 3'(v1) + 3'(v2) + 3'(v3);
  assign occupancy = (htpd_pkg::OutPtrW+2)'(out_count) + (htpd_pkg::OutPtrW+2)'(inflight);
  assign sample_stall = occupancy >= (htpd_pkg::OutPtrW+2)'(htpd_pkg::OutDepth);

  assign result_valid = out_count != '0;
  assign pop          = result_valid & ~result_stall;
  assign head         = out_queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_count <= '0;
    end else begin
      if (v3) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      out_count <= out_count + (htpd_pkg::OutPtrW+1)'(v3) - (htpd_pkg::OutPtrW+1)'(pop);
    end
    if (v3) begin
      out_queue[wr_ptr] <= d_result;
    end
  end

  assign drive_valid   = head.drive_valid;
  assign right_compare = head.right_compare;
  assign right_reverse = head.right_reverse;
  assign left_compare  = head.left_compare;
  assign left_reverse  = head.left_reverse;
  assign turn_done     = head.turn_done;
  assign phase_now     = head.phase_now;

endmodule

/* test/tb_top.sv */
// Self-checking bench for heading_turn_pid_drive: yaw requests in, drive results out.
// Predicts each result in-bench, compares field by field; configures over the APB port.
// Depends on htpd_pkg (register indexes, phase codes, result_t) and the RTL top.
`timescale 1ns / 1ps

module tb_top;

  localparam int PwmPeriod = 2000;
  localparam int AvgSamples = 10;
  localparam int ConfirmNeed = 3;
  localparam int BandCntTop = 131071;
  localparam longint AccTop = 64'sh0000_7fff_ffff_ffff;
  localparam longint AccBottom = -AccTop - 1;
  localparam int QuietLimit = 3000;
  localparam int IdlePct = 27;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic start_req = 1'b0;
  logic signed [15:0] yaw = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic drive_valid;
  logic [10:0] right_compare;
  logic right_reverse;
  logic [10:0] left_compare;
  logic left_reverse;
  logic turn_done;
  logic [1:0] phase_now;

  heading_turn_pid_drive #(
    .PWM_PERIOD(PwmPeriod),
    .AVERAGE_SAMPLES(AvgSamples)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .start_req(start_req),
    .yaw(yaw),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .drive_valid(drive_valid),
    .right_compare(right_compare),
    .right_reverse(right_reverse),
    .left_compare(left_compare),
    .left_reverse(left_reverse),
    .turn_done(turn_done),
    .phase_now(phase_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Register copies, reset values
  logic signed [15:0] cfg_turn = -16'sd16384;
  longint cfg_gp = 34560;
  longint cfg_gi = 605;
  longint cfg_gd = 17280;
  int cfg_band = 364;
  int cfg_settle = 100000;
  int cfg_dmin = 150;
  int cfg_dmax = 1100;

  // Controller state as the bench sees it
  logic [1:0] m_phase = htpd_pkg::PhaseIdle;
  int m_count = 0;
  int m_yaw_sum = 0;
  logic signed [15:0] m_target = '0;
  logic signed [15:0] m_last_err = '0;
  longint m_integ = 0;
  bit m_confirmed = 1'b0;
  int m_band_cnt = 0;

  htpd_pkg::result_t pending_drive[$];
  int mismatches = 0;
  bit steady = 1'b0;
  int hold_left = 0;

  function automatic logic [11:0] pwm_map(input int duty);
    int cmp;
    logic rev;
    if (duty < 0) begin
      cmp = (duty <= -PwmPeriod) ? 1 : PwmPeriod + duty;
      rev = 1'b1;
    end else begin
      cmp = (duty == 0) ? 1 : duty;
      rev = 1'b0;
    end
    if (cmp > PwmPeriod) cmp = PwmPeriod;
    return {cmp[10:0], rev};
  endfunction

  function automatic htpd_pkg::result_t predict_drive(input logic start,
                                                      input logic signed [15:0] yaw_in);
    htpd_pkg::result_t r;
    logic signed [15:0] err;
    int err_mag;
    bit in_band;
    longint pid_sum;
    longint integ_next;
    longint mag;
    int duty;
    r = '0;
    if (start) begin
      m_phase = htpd_pkg::PhaseAvg;
      m_count = 0;
      m_yaw_sum = 0;
      m_last_err = '0;
      m_integ = 0;
      m_confirmed = 1'b0;
      m_band_cnt = 0;
    end
    if (m_phase == htpd_pkg::PhaseAvg) begin
      r.phase_now = htpd_pkg::PhaseAvg;
      m_yaw_sum += yaw_in;
      m_count = (m_count + 1) & 15;
      if (m_count >= AvgSamples) begin
        m_target = 16'(m_yaw_sum / AvgSamples + int'(cfg_turn));
        m_phase = htpd_pkg::PhaseRun;
      end
      return r;
    end
    if (m_phase != htpd_pkg::PhaseRun) begin
      m_phase = htpd_pkg::PhaseIdle;
      return r;
    end
    r.phase_now = htpd_pkg::PhaseRun;
    err = m_target - yaw_in;
    err_mag = (err < 0) ? -int'(err) : int'(err);
    in_band = err_mag < cfg_band;
    if (in_band && !m_confirmed) begin
      if (m_band_cnt < BandCntTop) m_band_cnt++;
      if (m_band_cnt >= ConfirmNeed) begin
        m_confirmed = 1'b1;
        m_band_cnt = 0;
      end
    end
    if (m_confirmed) begin
      if (m_band_cnt > cfg_settle) begin
        // settled: stop both wheels, no PID update
        m_confirmed = 1'b0;
        m_band_cnt = 0;
        m_phase = htpd_pkg::PhaseIdle;
        r.drive_valid = 1'b1;
        r.right_compare = 11'd1;
        r.left_compare = 11'd1;
        r.turn_done = 1'b1;
        return r;
      end else if (in_band) begin
        if (m_band_cnt < BandCntTop) m_band_cnt++;
      end else begin
        m_confirmed = 1'b0;
        m_band_cnt = 0;
      end
    end
    pid_sum = cfg_gp * longint'(err) + cfg_gd * longint'(int'(err) - int'(m_last_err)) + m_integ;
    integ_next = m_integ + cfg_gi * longint'(err);
    if (integ_next > AccTop) integ_next = AccTop;
    if (integ_next < AccBottom) integ_next = AccBottom;
    m_integ = integ_next;
    m_last_err = err;
    mag = ((pid_sum >= 0) ? pid_sum : -pid_sum) >> 20;
    if (mag > cfg_dmax) mag = cfg_dmax;
    if (mag < cfg_dmin) mag = cfg_dmin;
    duty = (pid_sum >= 0) ? int'(mag) : -int'(mag);
    r.drive_valid = 1'b1;
    {r.right_compare, r.right_reverse} = pwm_map(duty);
    {r.left_compare, r.left_reverse} = pwm_map(-duty);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want_v,
                                      input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // Result side: check accepted results, drive stall
  always @(posedge clk) begin : result_rx
    htpd_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_drive.size() == 0) begin
        $display("%0t result with none expected: expected nothing, got phase %0d", $time,
                 phase_now);
        mismatches++;
      end else begin
        want = pending_drive.pop_front();
        check_field("drive_valid", want.drive_valid, drive_valid);
        check_field("right_compare", want.right_compare, right_compare);
        check_field("right_reverse", want.right_reverse, right_reverse);
        check_field("left_compare", want.left_compare, left_compare);
        check_field("left_reverse", want.left_reverse, left_reverse);
        check_field("turn_done", want.turn_done, turn_done);
        check_field("phase_now", want.phase_now, phase_now);
      end
    end
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      result_stall <= !steady && ($urandom_range(99) < IdlePct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_sample(input logic start, input logic signed [15:0] yaw_val);
    while (!steady && $urandom_range(99) < IdlePct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    start_req <= start;
    yaw <= yaw_val;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    pending_drive.push_back(predict_drive(start, yaw_val));
  endtask

  // Hold requests until every result is back, then let the pipeline empty
  task automatic wait_results_drained();
    sample_valid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      htpd_pkg::RegTurnAngle: cfg_turn = val[15:0];
      htpd_pkg::RegGainProp:  cfg_gp = val[19:0];
      htpd_pkg::RegGainInteg: cfg_gi = val[19:0];
      htpd_pkg::RegGainDeriv: cfg_gd = val[19:0];
      htpd_pkg::RegBandWidth: cfg_band = val[14:0];
      htpd_pkg::RegSettle:    cfg_settle = val[16:0];
      htpd_pkg::RegDriveMin:  cfg_dmin = val[10:0];
      htpd_pkg::RegDriveMax:  cfg_dmax = val[10:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int turn, input int gp, input int gi, input int gd,
                               input int band, input int settle, input int dmin, input int dmax);
    reg_write(htpd_pkg::RegTurnAngle, 32'(turn));
    reg_write(htpd_pkg::RegGainProp, 32'(gp));
    reg_write(htpd_pkg::RegGainInteg, 32'(gi));
    reg_write(htpd_pkg::RegGainDeriv, 32'(gd));
    reg_write(htpd_pkg::RegBandWidth, 32'(band));
    reg_write(htpd_pkg::RegSettle, 32'(settle));
    reg_write(htpd_pkg::RegDriveMin, 32'(dmin));
    reg_write(htpd_pkg::RegDriveMax, 32'(dmax));
  endtask

  function automatic int jitter(input int spread);
    return int'($urandom_range(2 * spread)) - spread;
  endfunction

  // Heading error for the next turning sample: mostly in band, some at the edge
  function automatic int pick_err(input int span);
    int sel;
    int inner;
    sel = $urandom_range(99);
    inner = cfg_band - 1;
    if (sel < 70 && inner >= 0) return int'($urandom_range(2 * inner)) - inner;
    if (sel < 80) return $urandom_range(1) ? cfg_band - int'($urandom_range(1)) : -cfg_band;
    if (sel < 95) return jitter(span);
    case ($urandom_range(2))
      0: return -32768;
      1: return 32767;
      default: return jitter(32767);
    endcase
  endfunction

  task automatic run_turns(input int n_items, input int span);
    int sent;
    int center;
    int spread;
    int steps;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        send_sample(1'($urandom_range(1)), 16'($urandom));
        sent++;
      end else begin
        center = $urandom_range(65535);
        spread = ($urandom_range(3) == 0) ? 32767 : $urandom_range(400);
        send_sample(1'b1, 16'(center + jitter(spread)));
        repeat (AvgSamples - 1) send_sample(1'b0, 16'(center + jitter(spread)));
        sent += AvgSamples;
        steps = $urandom_range(60, 4);
        while (steps > 0 && m_phase == htpd_pkg::PhaseRun) begin
          // drop out now and then so the next start restarts a live turn
          if ($urandom_range(99) < 3) break;
          send_sample(1'b0, 16'(int'(m_target) - pick_err(span)));
          steps--;
          sent++;
          if ($urandom_range(99) < 2) wait_results_drained();
        end
        repeat ($urandom_range(2)) begin
          send_sample(1'b0, 16'($urandom));
          sent++;
        end
      end
    end
  endtask

  task automatic test_idle_samples();
    send_sample(1'b0, 16'h8000);
    send_sample(1'b0, 16'h7fff);
    send_sample(1'b0, 16'h0000);
  endtask

  task automatic test_turn_extremes();
    send_sample(1'b1, 16'h8000);
    for (int i = 1; i < AvgSamples; i++) send_sample(1'b0, i[0] ? 16'h7fff : 16'h8000);
    // error of half a turn wraps to the most negative value
    send_sample(1'b0, 16'(int'(m_target) + 32768));
    send_sample(1'b0, 16'(int'(m_target) - 32767));
    send_sample(1'b0, m_target);
  endtask

  task automatic test_turn_end();
    wait_results_drained();
    // min above max, widest band, end right after confirmation
    apply_setting(32767, 'hFFFFF, 0, 'hFFFFF, 32767, 0, 2000, 0);
    send_sample(1'b1, 16'h1234);
    repeat (AvgSamples - 1) send_sample(1'b0, 16'(16'h1234 + jitter(20)));
    send_sample(1'b0, m_target);
    send_sample(1'b0, 16'(int'(m_target) - 32766));
    send_sample(1'b0, 16'(int'(m_target) + 32766));
    send_sample(1'b0, 16'(int'(m_target) - 5));
    send_sample(1'b0, 16'h0000);
  endtask

  task automatic test_random_turns();
    repeat (2) begin
      wait_results_drained();
      apply_setting(int'($urandom_range(65535)) - 32768, $urandom_range(120000),
                    $urandom_range(3000), $urandom_range(60000), $urandom_range(3000, 100),
                    $urandom_range(12), $urandom_range(300), $urandom_range(2000, 600));
      run_turns(80, 4000);
    end
  endtask

  task automatic test_backpressure();
    wait_results_drained();
    apply_setting(int'($urandom_range(65535)) - 32768, 40000, 800, 20000, 1500, 6, 100, 1500);
    steady = 1'b1;
    hold_left <= 250;
    run_turns(60, 3000);
    steady = 1'b0;
  endtask

  task automatic test_drive_limits();
    wait_results_drained();
    apply_setting(32767, 'hFFFFF, 'hFFFFF, 'hFFFFF, 32767, 131071, 2000, 2000);
    run_turns(50, 32767);
    wait_results_drained();
    apply_setting(-32768, 0, 0, 0, 0, 0, 0, 0);
    run_turns(50, 32767);
    wait_results_drained();
    apply_setting(int'($urandom_range(65535)) - 32768, $urandom_range(80000),
                  $urandom_range(2000), $urandom_range(40000), $urandom_range(2500, 50),
                  $urandom_range(20), $urandom_range(2000, 800), $urandom_range(700));
    run_turns(50, 6000);
  endtask

  task automatic test_integral_saturation();
    int center;
    center = $urandom_range(65535);
    wait_results_drained();
    // drive follows the integral alone; wind it up negative, then unwind it
    apply_setting(int'($urandom_range(65535)) - 32768, 0, 'hFFFFF, 0, 0, 131071, 0, 2000);
    send_sample(1'b1, 16'(center));
    repeat (AvgSamples - 1) send_sample(1'b0, 16'(center + jitter(50)));
    steady = 1'b1;
    for (int i = 0; i < 100; i++) begin
      if (i == 40) steady = 1'b0;
      send_sample(1'b0, 16'(int'(m_target) + 32000 + int'($urandom_range(768))));
    end
    repeat (30) send_sample(1'b0, 16'(int'(m_target) - 32000 - int'($urandom_range(767))));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_samples();
    test_turn_extremes();
    test_turn_end();
    test_random_turns();
    test_backpressure();
    test_drive_limits();
    test_integral_saturation();
    wait_results_drained();
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
